// ===== rtl/lzwc_pkg.sv =====
// Shared constants and types for the LZW byte compressor.
// No dependencies; imported by every module of the block but the RAM.
package lzwc_pkg;

    localparam int MAX_CODE_BITS_DEF = 12;  // default widest code
    localparam int FIRST_CODE        = 256; // first code past the single bytes
    localparam int MIN_LEN           = 9;   // code length after reset or wrap
    localparam int LEN_W             = 5;   // holds code lengths up to 31
    localparam int BYTE_W            = 8;
    localparam int QUEUE_DEPTH       = 2;   // front-to-back item queue

    // Classification of an item made by the front end
    typedef struct packed {
        logic first;   // opens a new stream, no prefix yet
        logic last;    // closes the stream, flush after it
    } lzwc_kind_t;

    // Control bits of one packing command
    typedef struct packed {
        logic flush;     // pad and drain every remaining bit
        logic item_end;  // last command caused by this item
    } lzwc_cmd_ctl_t;

endpackage

// ===== rtl/lzwc_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// A read of the address written in the same cycle returns the new data.
module lzwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data <= wr_data;
            end
            else
            begin
                rd_data <= mem[rd_addr];
            end
        end
    end

endmodule

// ===== rtl/lzwc_front.sv =====
// Front end: accepts input items, tags stream start and end, queues them.
// Depends on lzwc_pkg.
module lzwc_front
    import lzwc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              in_last,
    output logic              q_valid,
    input  logic              q_ready,
    output logic [BYTE_W-1:0] q_byte,
    output lzwc_kind_t        q_kind
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [BYTE_W-1:0] byte_q_reg [QUEUE_DEPTH];
    lzwc_kind_t        kind_q_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              start_reg, start_next;
    logic              push, pop;

    assign in_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_byte   = byte_q_reg[rd_ptr_reg];
    assign q_kind   = kind_q_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        start_next  = start_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            start_next  = in_last;   // byte after a last one opens a new stream
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            start_reg  <= 1'b1;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            start_reg  <= start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            byte_q_reg[wr_ptr_reg]       <= in_byte;
            kind_q_reg[wr_ptr_reg].first <= start_reg;
            kind_q_reg[wr_ptr_reg].last  <= in_last;
        end
    end

endmodule

// ===== rtl/lzwc_engine.sv =====
// Back end: dictionary lookup, hit check, entry insertion and code commands.
// Depends on lzwc_pkg and lzwc_ram (pair table and dictionary).
module lzwc_engine
    import lzwc_pkg::*;
#(
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    output logic                     q_ready,
    input  logic [BYTE_W-1:0]        q_byte,
    input  lzwc_kind_t               q_kind,
    output logic                     cmd_valid,
    input  logic                     cmd_ready,
    output logic [MAX_CODE_BITS-1:0] cmd_code,
    output logic [LEN_W-1:0]         cmd_len,
    output lzwc_cmd_ctl_t            cmd_ctl
);

    localparam int CODE_W     = MAX_CODE_BITS;
    localparam int KEY_W      = CODE_W + BYTE_W;
    localparam int NFC_W      = CODE_W + 1;
    localparam int DICT_DEPTH = 1 << CODE_W;
    localparam int LK_DEPTH   = 1 << KEY_W;

    localparam logic [NFC_W-1:0]  NFC_FIRST = NFC_W'(FIRST_CODE);
    localparam logic [NFC_W-1:0]  NFC_FULL  = NFC_W'(DICT_DEPTH);
    localparam logic [CODE_W-1:0] CODE_LOW  = CODE_W'(FIRST_CODE);
    localparam logic [LEN_W-1:0]  LEN_MIN   = LEN_W'(MIN_LEN);
    localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(MAX_CODE_BITS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LOOK  = 2'd1;
    localparam logic [1:0] ST_CHECK = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CODE_W-1:0] prefix_reg, prefix_next;
    logic [NFC_W-1:0]  nfc_reg, nfc_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              last_reg, last_next;

    logic              cmd_valid_reg, cmd_valid_next;
    logic [CODE_W-1:0] cmd_code_reg, cmd_code_next;
    logic [LEN_W-1:0]  cmd_len_reg, cmd_len_next;
    lzwc_cmd_ctl_t     cmd_ctl_reg, cmd_ctl_next;

    logic              lk_rd_en, lk_wr_en;
    logic [KEY_W-1:0]  lk_rd_addr;
    logic [CODE_W-1:0] lk_rd_data;
    logic              dict_rd_en, dict_wr_en;
    logic [KEY_W-1:0]  dict_rd_data;

    logic [KEY_W-1:0]  key;
    logic              hit, full, grow, cmd_free, done, cmd_load;

    assign key      = {prefix_reg, byte_reg};
    assign full     = (nfc_reg == NFC_FULL);
    assign grow     = (len_reg < LEN_MAX) && (nfc_reg == (NFC_W'(1) << len_reg));
    assign cmd_free = !cmd_valid_reg || cmd_ready;

    // A hit needs a code in 256 .. nfc-1 whose entry holds this pair;
    // an unknown read of a never-written pair entry counts as a miss
    always_comb
    begin
        hit = 1'b0;
        if ((lk_rd_data >= CODE_LOW) && ({1'b0, lk_rd_data} < nfc_reg)
            && (dict_rd_data == key))
        begin
            hit = 1'b1;
        end
    end

    lzwc_ram #(
        .WIDTH (CODE_W),
        .DEPTH (LK_DEPTH)
    ) u_pair_ram (
        .clk     (clk),
        .wr_en   (lk_wr_en),
        .wr_addr (key),
        .wr_data (nfc_reg[CODE_W-1:0]),
        .rd_en   (lk_rd_en),
        .rd_addr (lk_rd_addr),
        .rd_data (lk_rd_data)
    );

    lzwc_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DICT_DEPTH)
    ) u_dict_ram (
        .clk     (clk),
        .wr_en   (dict_wr_en),
        .wr_addr (nfc_reg[CODE_W-1:0]),
        .wr_data (key),
        .rd_en   (dict_rd_en),
        .rd_addr (lk_rd_data),
        .rd_data (dict_rd_data)
    );

    always_comb
    begin
        state_next    = state_reg;
        prefix_next   = prefix_reg;
        nfc_next      = nfc_reg;
        len_next      = len_reg;
        byte_next     = byte_reg;
        last_next     = last_reg;
        cmd_load      = 1'b0;
        cmd_code_next = cmd_code_reg;
        cmd_len_next  = cmd_len_reg;
        cmd_ctl_next  = cmd_ctl_reg;
        lk_wr_en      = 1'b0;
        dict_wr_en    = 1'b0;
        lk_rd_en      = 1'b0;
        dict_rd_en    = 1'b0;
        done          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                done = 1'b1;
            end
            ST_LOOK:
            begin
                dict_rd_en = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (cmd_free || (hit && !last_reg))
                begin
                    if (hit)
                    begin
                        prefix_next = lk_rd_data;
                    end
                    else
                    begin
                        cmd_load              = 1'b1;
                        cmd_code_next         = prefix_reg;
                        cmd_len_next          = len_reg;
                        cmd_ctl_next.flush    = 1'b0;
                        cmd_ctl_next.item_end = !last_reg;
                        prefix_next           = CODE_W'(byte_reg);
                        if (full)
                        begin
                            nfc_next = NFC_FIRST;
                            len_next = LEN_MIN;
                        end
                        else
                        begin
                            lk_wr_en   = 1'b1;
                            dict_wr_en = 1'b1;
                            nfc_next   = nfc_reg + 1'b1;
                            if (grow)
                            begin
                                len_next = len_reg + 1'b1;
                            end
                        end
                    end
                    if (last_reg && !hit)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        if (last_reg)
                        begin
                            cmd_load              = 1'b1;
                            cmd_code_next         = lk_rd_data;
                            cmd_len_next          = len_reg;
                            cmd_ctl_next.flush    = 1'b1;
                            cmd_ctl_next.item_end = 1'b1;
                            nfc_next              = NFC_FIRST;
                            len_next              = LEN_MIN;
                        end
                        done       = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (cmd_free)
                begin
                    cmd_load              = 1'b1;
                    cmd_code_next         = prefix_reg;
                    cmd_len_next          = len_reg;
                    cmd_ctl_next.flush    = 1'b1;
                    cmd_ctl_next.item_end = 1'b1;
                    nfc_next              = NFC_FIRST;
                    len_next              = LEN_MIN;
                    done                  = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Take the next item as soon as the current one retires
        lk_rd_addr = {prefix_next, q_byte};
        if (done && q_valid)
        begin
            if (q_kind.first)
            begin
                prefix_next = CODE_W'(q_byte);
                state_next  = q_kind.last ? ST_FLUSH : ST_IDLE;
            end
            else
            begin
                lk_rd_en   = 1'b1;
                byte_next  = q_byte;
                last_next  = q_kind.last;
                state_next = ST_LOOK;
            end
        end

        if (cmd_load)
        begin
            cmd_valid_next = 1'b1;
        end
        else if (cmd_ready)
        begin
            cmd_valid_next = 1'b0;
        end
        else
        begin
            cmd_valid_next = cmd_valid_reg;
        end
    end

    assign q_ready   = done;
    assign cmd_valid = cmd_valid_reg;
    assign cmd_code  = cmd_code_reg;
    assign cmd_len   = cmd_len_reg;
    assign cmd_ctl   = cmd_ctl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prefix_reg    <= '0;
            nfc_reg       <= NFC_FIRST;
            len_reg       <= LEN_MIN;
            last_reg      <= 1'b0;
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prefix_reg    <= prefix_next;
            nfc_reg       <= nfc_next;
            len_reg       <= len_next;
            last_reg      <= last_next;
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        cmd_code_reg <= cmd_code_next;
        cmd_len_reg  <= cmd_len_next;
        cmd_ctl_reg  <= cmd_ctl_next;
    end

endmodule

// ===== rtl/lzwc_packer.sv =====
// Bit packer: appends codes LSB-first to a bit buffer, drains one byte a cycle while out_ready is high.
// Depends on lzwc_pkg.
module lzwc_packer
    import lzwc_pkg::*;
#(
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    output logic                     cmd_ready,
    input  logic [MAX_CODE_BITS-1:0] cmd_code,
    input  logic [LEN_W-1:0]         cmd_len,
    input  lzwc_cmd_ctl_t            cmd_ctl,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [BYTE_W-1:0]        out_byte,
    output logic                     out_run_last,
    output logic                     out_stream_end
);

    localparam int BUF_W = MAX_CODE_BITS + BYTE_W - 1;   // leftover bits plus one code
    localparam int CNT_W = $clog2(BUF_W + 1);
    localparam logic [CNT_W-1:0] CNT_BYTE = CNT_W'(BYTE_W);

    logic [BUF_W-1:0]  bits_reg, bits_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next, cnt_after;
    logic              flush_reg, flush_next;
    logic              item_end_reg, item_end_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_run_last_reg, out_run_last_next;
    logic              out_stream_end_reg, out_stream_end_next;
    logic              byte_avail, emit, more;

    assign byte_avail = (cnt_reg >= CNT_BYTE);
    assign emit       = (byte_avail || (flush_reg && (cnt_reg != '0)))
                        && (!out_valid_reg || out_ready);
    assign cmd_ready  = !byte_avail && !flush_reg;
    assign cnt_after  = byte_avail ? (cnt_reg - CNT_BYTE) : '0;
    assign more       = (cnt_after >= CNT_BYTE) || (flush_reg && (cnt_after != '0));

    always_comb
    begin
        bits_next           = bits_reg;
        cnt_next            = cnt_reg;
        flush_next          = flush_reg;
        item_end_next       = item_end_reg;
        out_valid_next      = out_valid_reg && !out_ready;
        out_byte_next       = out_byte_reg;
        out_run_last_next   = out_run_last_reg;
        out_stream_end_next = out_stream_end_reg;
        if (emit)
        begin
            out_valid_next      = 1'b1;
            out_byte_next       = bits_reg[BYTE_W-1:0];
            out_run_last_next   = item_end_reg && !more;
            out_stream_end_next = flush_reg && !more;
            bits_next           = bits_reg >> BYTE_W;
            cnt_next            = cnt_after;
            if (cnt_after == '0)
            begin
                flush_next = 1'b0;
            end
        end
        else if (cmd_valid && cmd_ready)
        begin
            bits_next     = bits_reg | (BUF_W'(cmd_code) << cnt_reg);
            cnt_next      = cnt_reg + CNT_W'(cmd_len);
            flush_next    = cmd_ctl.flush;
            item_end_next = cmd_ctl.item_end;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign out_run_last   = out_run_last_reg;
    assign out_stream_end = out_stream_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg      <= '0;
            cnt_reg       <= '0;
            flush_reg     <= 1'b0;
            item_end_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bits_reg      <= bits_next;
            cnt_reg       <= cnt_next;
            flush_reg     <= flush_next;
            item_end_reg  <= item_end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg       <= out_byte_next;
        out_run_last_reg   <= out_run_last_next;
        out_stream_end_reg <= out_stream_end_next;
    end

endmodule

// ===== rtl/lzw_byte_compressor_core.sv =====
// LZW byte compressor, 9 to MAX_CODE_BITS bit codes, packed LSB-first into bytes.
// Per continuing byte the engine reads the pair table, then reads the dictionary
// and compares; a stream's first byte skips both reads, and a flush step follows
// a miss on a stream's last byte or a one-byte stream. The packer takes each code,
// then drains its bytes; output drains 1 byte per cycle while out_ready is high.
// Reset (rst_n, async, active low) clears control state only; the pair table and
// dictionary RAMs keep their contents and need no clearing pass.
module lzw_byte_compressor_core
    import lzwc_pkg::*;
#(
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              in_last,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic              out_run_last,
    output logic              out_stream_end
);

    // Front end to engine: queued byte plus its stream position
    logic              q_valid;
    logic              q_ready;
    logic [BYTE_W-1:0] q_byte;
    lzwc_kind_t        q_kind;

    // Engine to packer: one code with its length and flush control
    logic                     cmd_valid;
    logic                     cmd_ready;
    logic [MAX_CODE_BITS-1:0] cmd_code;
    logic [LEN_W-1:0]         cmd_len;
    lzwc_cmd_ctl_t            cmd_ctl;

    // Front end: takes an item whenever the queue has room; input waits only
    // once a stalled back end has let the queue fill up.
    lzwc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_byte   (q_byte),
        .q_kind   (q_kind)
    );

    // Engine: the next item's pair lookup is issued in the same cycle the
    // current item resolves, with no idle state between queued items.
    lzwc_engine #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_byte    (q_byte),
        .q_kind    (q_kind),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_code  (cmd_code),
        .cmd_len   (cmd_len),
        .cmd_ctl   (cmd_ctl)
    );

    // Packer: takes a new code only once fewer than 8 bits remain buffered,
    // then drains whole bytes (and the padded tail on a flush).
    lzwc_packer #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_packer (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .cmd_code       (cmd_code),
        .cmd_len        (cmd_len),
        .cmd_ctl        (cmd_ctl),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .out_run_last   (out_run_last),
        .out_stream_end (out_stream_end)
    );

    // The closing byte of a stream is always the closing byte of its item
    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stream_end |-> out_run_last)
        else $error("stream end without run last");

    // Code lengths stay within the legal range
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> (cmd_len >= LEN_W'(MIN_LEN)) && (cmd_len <= LEN_W'(MAX_CODE_BITS)))
        else $error("code length out of range");

    // Every code fits its length, otherwise packing would corrupt later bits
    a_code_fits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> ((cmd_code >> cmd_len) == '0))
        else $error("code wider than its length");

endmodule
